### src/qvr_pkg.sv
// ---------------------------------------------------------------------------
// qvr_pkg
// Shared types, constants and width helpers for the quaternion rotator.
// ---------------------------------------------------------------------------
package qvr_pkg;

  localparam int QUAT_W             = 16;
  localparam int VEC_WIDTH_DEF      = 16;
  localparam int QUAT_FRAC_BITS_DEF = 14;
  localparam int CFG_IDX_W          = 8;
  localparam int NUM_STAGES         = 5;
  // low slice of a first-product sum taken apart for the second multiply
  localparam int SPLIT_W            = 16;
  // coefficient width: a negated component needs one bit more
  localparam int COEF_W             = QUAT_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_QUAT_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_Y = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_Z = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_W = CFG_IDX_W'(3);

  localparam logic signed [QUAT_W-1:0] QUAT_ONE = QUAT_W'(16384);

  typedef struct packed {
    logic signed [QUAT_W-1:0] x;
    logic signed [QUAT_W-1:0] y;
    logic signed [QUAT_W-1:0] z;
    logic signed [QUAT_W-1:0] w;
  } quat_t;

  // width of one q*v sum (three products, negation included)
  function automatic int prod1_w(input int vw);
    return vw + QUAT_W + 2;
  endfunction

  // width of the sum of four high partial products
  function automatic int hi_sum_w(input int vw);
    return prod1_w(vw) - SPLIT_W + COEF_W + 2;
  endfunction

  // width of the sum of four low partial products
  function automatic int lo_sum_w(input int vw);
    return SPLIT_W + 1 + COEF_W + 2;
  endfunction

endpackage

### src/qvr_if.sv
// ---------------------------------------------------------------------------
// qvr_if
// Stream and configuration channels of the quaternion rotator.
// ---------------------------------------------------------------------------
interface qvr_vec_if #(
  parameter int W = qvr_pkg::VEC_WIDTH_DEF
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] vec_x;
  logic signed [W-1:0] vec_y;
  logic signed [W-1:0] vec_z;

  modport source (output valid, vec_x, vec_y, vec_z, input ready);
  modport sink   (input valid, vec_x, vec_y, vec_z, output ready);
endinterface

interface qvr_rot_if #(
  parameter int W = qvr_pkg::VEC_WIDTH_DEF
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] rot_x;
  logic signed [W-1:0] rot_y;
  logic signed [W-1:0] rot_z;
  logic                saturated;

  modport source (output valid, rot_x, rot_y, rot_z, saturated, input ready);
  modport sink   (input valid, rot_x, rot_y, rot_z, saturated, output ready);
endinterface

interface qvr_cfg_if;
  logic                                   valid;
  logic                                   ready;
  logic [qvr_pkg::CFG_IDX_W-1:0]          index;
  logic [qvr_pkg::QUAT_W-1:0]             data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### src/qvr_cfg_regs.sv
// ---------------------------------------------------------------------------
// qvr_cfg_regs
// Quaternion register file, written one component per configuration beat.
// ---------------------------------------------------------------------------
module qvr_cfg_regs (
  input  logic                   clk,
  input  logic                   rst,
  qvr_cfg_if.sink                cfg,
  output qvr_pkg::quat_t         quat
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      quat.x <= '0;
      quat.y <= '0;
      quat.z <= '0;
      quat.w <= qvr_pkg::QUAT_ONE;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        qvr_pkg::REG_QUAT_X: quat.x <= cfg.data;
        qvr_pkg::REG_QUAT_Y: quat.y <= cfg.data;
        qvr_pkg::REG_QUAT_Z: quat.z <= cfg.data;
        qvr_pkg::REG_QUAT_W: quat.w <= cfg.data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

endmodule

### src/qvr_pipe_ctl.sv
// ---------------------------------------------------------------------------
// qvr_pipe_ctl
// Valid bits and per-stage advance enables; bubbles close up under stall.
// ---------------------------------------------------------------------------
module qvr_pipe_ctl #(
  parameter int N = qvr_pkg::NUM_STAGES
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic         out_ready,
  output logic         in_ready,
  output logic [N-1:0] en,
  output logic [N-1:0] vld
);

  always_comb begin
    en[N-1] = !vld[N-1] || out_ready;
    for (int i = N - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < N; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (&vld))
    else $error("input blocked while a stage is empty");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    vld[N-1] && out_ready && !vld[N-2] |=> !vld[N-1])
    else $error("output stage kept a beat that was taken");

  a_first_hold: assert property (@(posedge clk) disable iff (rst)
    !en[0] |=> vld[0])
    else $error("stalled first stage lost its beat");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (vld == '0))
    else $error("pipeline not empty after reset");

endmodule

### src/qvr_first_prod.sv
// ---------------------------------------------------------------------------
// qvr_first_prod
// q * v with v pure: twelve component products, then the four sums.
// ---------------------------------------------------------------------------
module qvr_first_prod #(
  parameter int VW = qvr_pkg::VEC_WIDTH_DEF
) (
  input  logic                                      clk,
  input  logic [1:0]                                en,
  input  qvr_pkg::quat_t                            quat,
  input  logic signed [VW-1:0]                      vx,
  input  logic signed [VW-1:0]                      vy,
  input  logic signed [VW-1:0]                      vz,
  output logic signed [qvr_pkg::prod1_w(VW)-1:0]    px,
  output logic signed [qvr_pkg::prod1_w(VW)-1:0]    py,
  output logic signed [qvr_pkg::prod1_w(VW)-1:0]    pz,
  output logic signed [qvr_pkg::prod1_w(VW)-1:0]    pw
);

  localparam int MW = qvr_pkg::QUAT_W + VW;
  localparam int PW = qvr_pkg::prod1_w(VW);

  // prod[component x,y,z,w][coordinate x,y,z]
  logic signed [MW-1:0]             prod [4][3];
  logic signed [qvr_pkg::QUAT_W-1:0] qa  [4];
  logic signed [VW-1:0]             va  [3];

  assign qa[0] = quat.x;
  assign qa[1] = quat.y;
  assign qa[2] = quat.z;
  assign qa[3] = quat.w;
  assign va[0] = vx;
  assign va[1] = vy;
  assign va[2] = vz;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int c = 0; c < 4; c++) begin
        for (int k = 0; k < 3; k++) begin
          prod[c][k] <= MW'(qa[c] * va[k]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      px <= PW'(prod[3][0]) + PW'(prod[1][2]) - PW'(prod[2][1]);
      py <= PW'(prod[3][1]) + PW'(prod[2][0]) - PW'(prod[0][2]);
      pz <= PW'(prod[3][2]) + PW'(prod[0][1]) - PW'(prod[1][0]);
      pw <= -(PW'(prod[0][0]) + PW'(prod[1][1]) + PW'(prod[2][2]));
    end
  end

endmodule

### src/qvr_second_prod.sv
// ---------------------------------------------------------------------------
// qvr_second_prod
// (q * v) * conj(q), vector part only. Each first-product sum is split in a
// signed high part and a 16-bit low part so each multiply stays narrow.
// ---------------------------------------------------------------------------
module qvr_second_prod #(
  parameter int VW = qvr_pkg::VEC_WIDTH_DEF
) (
  input  logic                                      clk,
  input  logic [1:0]                                en,
  input  qvr_pkg::quat_t                            quat,
  input  logic signed [qvr_pkg::prod1_w(VW)-1:0]    px,
  input  logic signed [qvr_pkg::prod1_w(VW)-1:0]    py,
  input  logic signed [qvr_pkg::prod1_w(VW)-1:0]    pz,
  input  logic signed [qvr_pkg::prod1_w(VW)-1:0]    pw,
  output logic signed [qvr_pkg::hi_sum_w(VW)-1:0]   sum_hi [3],
  output logic signed [qvr_pkg::lo_sum_w(VW)-1:0]   sum_lo [3]
);

  localparam int PW  = qvr_pkg::prod1_w(VW);
  localparam int SW  = qvr_pkg::SPLIT_W;
  localparam int BW  = qvr_pkg::COEF_W;
  localparam int AHW = PW - SW;
  localparam int HW  = AHW + BW;
  localparam int LW  = SW + 1 + BW;
  localparam int SHW = qvr_pkg::hi_sum_w(VW);
  localparam int SLW = qvr_pkg::lo_sum_w(VW);

  logic signed [PW-1:0] a  [3][4];
  logic signed [BW-1:0] b  [3][4];
  logic signed [HW-1:0] ph [3][4];
  logic signed [LW-1:0] pl [3][4];
  logic signed [BW-1:0] bx, by, bz, bw, nx, ny, nz;

  assign bx = BW'(quat.x);
  assign by = BW'(quat.y);
  assign bz = BW'(quat.z);
  assign bw = BW'(quat.w);
  assign nx = -bx;
  assign ny = -by;
  assign nz = -bz;

  // x: -pw*x + px*w - py*z + pz*y
  assign a[0][0] = pw; assign b[0][0] = nx;
  assign a[0][1] = px; assign b[0][1] = bw;
  assign a[0][2] = py; assign b[0][2] = nz;
  assign a[0][3] = pz; assign b[0][3] = by;
  // y: -pw*y + py*w - pz*x + px*z
  assign a[1][0] = pw; assign b[1][0] = ny;
  assign a[1][1] = py; assign b[1][1] = bw;
  assign a[1][2] = pz; assign b[1][2] = nx;
  assign a[1][3] = px; assign b[1][3] = bz;
  // z: -pw*z + pz*w - px*y + py*x
  assign a[2][0] = pw; assign b[2][0] = nz;
  assign a[2][1] = pz; assign b[2][1] = bw;
  assign a[2][2] = px; assign b[2][2] = ny;
  assign a[2][3] = py; assign b[2][3] = bx;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < 3; k++) begin
        for (int t = 0; t < 4; t++) begin
          ph[k][t] <= HW'($signed(a[k][t][PW-1:SW]) * b[k][t]);
          pl[k][t] <= LW'($signed({1'b0, a[k][t][SW-1:0]}) * b[k][t]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int k = 0; k < 3; k++) begin
        sum_hi[k] <= SHW'(ph[k][0]) + SHW'(ph[k][1]) + SHW'(ph[k][2]) + SHW'(ph[k][3]);
        sum_lo[k] <= SLW'(pl[k][0]) + SLW'(pl[k][1]) + SLW'(pl[k][2]) + SLW'(pl[k][3]);
      end
    end
  end

endmodule

### src/qvr_round_sat.sv
// ---------------------------------------------------------------------------
// qvr_round_sat
// Join the partial sums, shift out the fraction (floor) and clip to range.
// ---------------------------------------------------------------------------
module qvr_round_sat #(
  parameter int VW  = qvr_pkg::VEC_WIDTH_DEF,
  parameter int QFB = qvr_pkg::QUAT_FRAC_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      en,
  input  logic signed [qvr_pkg::hi_sum_w(VW)-1:0]   sum_hi [3],
  input  logic signed [qvr_pkg::lo_sum_w(VW)-1:0]   sum_lo [3],
  output logic signed [VW-1:0]                      rot    [3],
  output logic                                      saturated
);

  localparam int TW    = qvr_pkg::hi_sum_w(VW) + qvr_pkg::SPLIT_W + 1;
  localparam int SHIFT = 2 * QFB;
  localparam logic signed [TW-1:0] SAT_MAX = TW'((64'sd1 <<< (VW - 1)) - 64'sd1);
  localparam logic signed [TW-1:0] SAT_MIN = ~SAT_MAX;

  logic signed [VW-1:0] rot_next [3];
  logic                 saturated_next;

  always_comb begin
    logic signed [TW-1:0] total;
    logic signed [TW-1:0] shifted;
    saturated_next = 1'b0;
    for (int k = 0; k < 3; k++) begin
      total   = (TW'(sum_hi[k]) <<< qvr_pkg::SPLIT_W) + TW'(sum_lo[k]);
      shifted = total >>> SHIFT;
      priority if (shifted > SAT_MAX) begin
        rot_next[k]    = SAT_MAX[VW-1:0];
        saturated_next = 1'b1;
      end else if (shifted < SAT_MIN) begin
        rot_next[k]    = SAT_MIN[VW-1:0];
        saturated_next = 1'b1;
      end else begin
        rot_next[k] = shifted[VW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot       <= rot_next;
      saturated <= saturated_next;
    end
  end

endmodule

### src/quaternion_vector_rotate.sv
// ---------------------------------------------------------------------------
// quaternion_vector_rotate
// Rotates a stream of 3D vectors by the configured quaternion, q * v * q'.
//
//   channel  dir  payload                               beat when
//   cfg      in   index, data (16-bit component)        cfg.valid & cfg.ready
//   vec      in   vec_x, vec_y, vec_z                   vec.valid & vec.ready
//   rot      out  rot_x, rot_y, rot_z, saturated        rot.valid & rot.ready
//
// One vector per cycle while rot.ready is high; rot.valid rises once the input
// beat has passed through every stage below.
// Stages: q*v products, q*v sums, split products with conj(q), partial sums,
// shift and clip into the output register.
// Stalls hold every full stage; empty stages keep filling, so bubbles close.
// rst empties the pipeline and loads q = (0, 0, 0, 1.0); cfg.ready is always
// high and a write takes effect on the next cycle.
// ---------------------------------------------------------------------------
module quaternion_vector_rotate #(
  parameter int VEC_WIDTH      = qvr_pkg::VEC_WIDTH_DEF,
  parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  qvr_cfg_if.sink    cfg,
  qvr_vec_if.sink    vec,
  qvr_rot_if.source  rot
);

  localparam int NS  = qvr_pkg::NUM_STAGES;
  localparam int PW  = qvr_pkg::prod1_w(VEC_WIDTH);
  localparam int SHW = qvr_pkg::hi_sum_w(VEC_WIDTH);
  localparam int SLW = qvr_pkg::lo_sum_w(VEC_WIDTH);

  qvr_pkg::quat_t              quat;
  logic [NS-1:0]               en;
  logic [NS-1:0]               vld;
  logic                        in_ready;
  logic signed [PW-1:0]        px, py, pz, pw;
  logic signed [SHW-1:0]       sum_hi [3];
  logic signed [SLW-1:0]       sum_lo [3];
  logic signed [VEC_WIDTH-1:0] rot_v  [3];
  logic                        sat;

  qvr_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .quat (quat)
  );

  qvr_pipe_ctl #(.N(NS)) u_pipe_ctl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vec.valid),
    .out_ready (rot.ready),
    .in_ready  (in_ready),
    .en        (en),
    .vld       (vld)
  );

  qvr_first_prod #(.VW(VEC_WIDTH)) u_first_prod (
    .clk  (clk),
    .en   (en[1:0]),
    .quat (quat),
    .vx   (vec.vec_x),
    .vy   (vec.vec_y),
    .vz   (vec.vec_z),
    .px   (px),
    .py   (py),
    .pz   (pz),
    .pw   (pw)
  );

  qvr_second_prod #(.VW(VEC_WIDTH)) u_second_prod (
    .clk    (clk),
    .en     (en[3:2]),
    .quat   (quat),
    .px     (px),
    .py     (py),
    .pz     (pz),
    .pw     (pw),
    .sum_hi (sum_hi),
    .sum_lo (sum_lo)
  );

  qvr_round_sat #(.VW(VEC_WIDTH), .QFB(QUAT_FRAC_BITS)) u_round_sat (
    .clk       (clk),
    .en        (en[NS-1]),
    .sum_hi    (sum_hi),
    .sum_lo    (sum_lo),
    .rot       (rot_v),
    .saturated (sat)
  );

  assign vec.ready     = in_ready;
  assign rot.valid     = vld[NS-1];
  assign rot.rot_x     = rot_v[0];
  assign rot.rot_y     = rot_v[1];
  assign rot.rot_z     = rot_v[2];
  assign rot.saturated = sat;

endmodule
